// ===== rtl/core/nearest_neighbor_image_scaler_unit_assert.svh =====
// Assertion helpers shared by the scaler modules.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NNIS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scaler assertion failed");

// Next-cycle implication, disabled during reset.
`define NNIS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scaler assertion failed");

`endif

// ===== rtl/core/nnis_pkg.sv =====
package nnis_pkg;

   // Frame store and output image limits.
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_DST_SIZE   = 1024;

   // Field widths of the ports.
   localparam int POS_W       = 10;
   localparam int SRC_SIZE_W  = 9;
   localparam int DST_SIZE_W  = 11;
   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   // Frame store geometry.
   localparam int SX_W        = $clog2(MAX_SRC_WIDTH);
   localparam int SY_W        = $clog2(MAX_SRC_HEIGHT);
   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Divider sizing: the quotient is always below the source size.
   localparam int Q_W    = (SX_W > SY_W) ? SX_W : SY_W;
   localparam int PROD_W = POS_W + SRC_SIZE_W;
   localparam int DSH_W  = DST_SIZE_W + Q_W - 1;
   localparam int DIV_W  = (PROD_W > DSH_W) ? PROD_W : DSH_W;
   localparam int STEP_W = $clog2(Q_W + 1);

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [SRC_SIZE_W-1:0] SRC_WIDTH_RESET  = SRC_SIZE_W'(256);
   localparam logic [SRC_SIZE_W-1:0] SRC_HEIGHT_RESET = SRC_SIZE_W'(256);
   localparam logic [DST_SIZE_W-1:0] DST_WIDTH_RESET  = DST_SIZE_W'(256);
   localparam logic [DST_SIZE_W-1:0] DST_HEIGHT_RESET = DST_SIZE_W'(256);

   // Request kinds on the input channel.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } nnis_csr_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_FETCH = 2'd1,
      OP_FAULT = 2'd2
   } nnis_op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_DIVIDE  = 2'd1,
      ST_ADDRESS = 2'd2,
      ST_DELIVER = 2'd3
   } nnis_state_type;

   // One classified word waiting for the back part.
   typedef struct packed {
      nnis_op_type             op;
      logic [ADDR_W-1:0]       addr;
      logic [PIXEL_W-1:0]      pixel;
      logic [PROD_W-1:0]       num_x;
      logic [PROD_W-1:0]       num_y;
      logic [DST_SIZE_W-1:0]   den_x;
      logic [DST_SIZE_W-1:0]   den_y;
   } nnis_entry_type;

   typedef struct packed {
      logic                    start;
      logic [PROD_W-1:0]       num_x;
      logic [PROD_W-1:0]       num_y;
      logic [DST_SIZE_W-1:0]   den_x;
      logic [DST_SIZE_W-1:0]   den_y;
   } nnis_div_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [SX_W-1:0]         quot_x;
      logic [SY_W-1:0]         quot_y;
   } nnis_div_rsp_type;

endpackage

// ===== rtl/core/nnis_ram.sv =====
module nnis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nnis_front.sv =====
module nnis_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [nnis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 push,
   input  logic                                 full,
   input  logic                                 req_type,
   input  logic [nnis_pkg::POS_W-1:0]           pos_x,
   input  logic [nnis_pkg::POS_W-1:0]           pos_y,
   input  logic [nnis_pkg::COLOR_W-1:0]         in_red,
   input  logic [nnis_pkg::COLOR_W-1:0]         in_green,
   input  logic [nnis_pkg::COLOR_W-1:0]         in_blue,
   output logic                                 enq_valid,
   output nnis_pkg::nnis_entry_type             enq_entry
);

   logic [nnis_pkg::SRC_SIZE_W-1:0] src_width_ff;
   logic [nnis_pkg::SRC_SIZE_W-1:0] src_height_ff;
   logic [nnis_pkg::DST_SIZE_W-1:0] dst_width_ff;
   logic [nnis_pkg::DST_SIZE_W-1:0] dst_height_ff;
   logic                            sizes_ok;
   logic                            load_ok;
   logic                            fetch_ok;
   logic                            accept;

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nnis_pkg::SRC_WIDTH_RESET;
         src_height_ff <= nnis_pkg::SRC_HEIGHT_RESET;
         dst_width_ff  <= nnis_pkg::DST_WIDTH_RESET;
         dst_height_ff <= nnis_pkg::DST_HEIGHT_RESET;
      end else if (csr_we) begin
         case (nnis_pkg::nnis_csr_type'(csr_index))
            nnis_pkg::CSR_SRC_WIDTH: begin
               src_width_ff <= csr_wdata[nnis_pkg::SRC_SIZE_W-1:0];
            end
            nnis_pkg::CSR_SRC_HEIGHT: begin
               src_height_ff <= csr_wdata[nnis_pkg::SRC_SIZE_W-1:0];
            end
            nnis_pkg::CSR_DST_WIDTH: begin
               dst_width_ff <= csr_wdata[nnis_pkg::DST_SIZE_W-1:0];
            end
            nnis_pkg::CSR_DST_HEIGHT: begin
               dst_height_ff <= csr_wdata[nnis_pkg::DST_SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sizes must be nonzero and within the store and output limits.
   assign sizes_ok = (src_width_ff != '0) && (src_height_ff != '0) &&
                     (dst_width_ff != '0) && (dst_height_ff != '0) &&
                     (32'(src_width_ff) <= 32'(nnis_pkg::MAX_SRC_WIDTH)) &&
                     (32'(src_height_ff) <= 32'(nnis_pkg::MAX_SRC_HEIGHT)) &&
                     (32'(dst_width_ff) <= 32'(nnis_pkg::MAX_DST_SIZE)) &&
                     (32'(dst_height_ff) <= 32'(nnis_pkg::MAX_DST_SIZE));

   // A load outside the source image is dropped here.
   assign load_ok = (32'(pos_x) < 32'(src_width_ff)) &&
                    (32'(pos_y) < 32'(src_height_ff)) &&
                    (32'(pos_x) < 32'(nnis_pkg::MAX_SRC_WIDTH)) &&
                    (32'(pos_y) < 32'(nnis_pkg::MAX_SRC_HEIGHT));

   assign fetch_ok = sizes_ok &&
                     (32'(pos_x) < 32'(dst_width_ff)) &&
                     (32'(pos_y) < 32'(dst_height_ff));

   assign accept = push && !full;

   // Classify the word and prepare the dividends for the back part.
   always_comb begin
      enq_valid = accept && ((req_type == nnis_pkg::REQ_FETCH) || load_ok);
      if (req_type == nnis_pkg::REQ_FETCH) begin
         enq_entry.op = fetch_ok ? nnis_pkg::OP_FETCH : nnis_pkg::OP_FAULT;
      end else begin
         enq_entry.op = nnis_pkg::OP_LOAD;
      end
      enq_entry.addr  = nnis_pkg::ADDR_W'(pos_y) *
                        nnis_pkg::ADDR_W'(nnis_pkg::MAX_SRC_WIDTH) +
                        nnis_pkg::ADDR_W'(pos_x);
      enq_entry.pixel = {in_red, in_green, in_blue};
      enq_entry.num_x = nnis_pkg::PROD_W'(pos_x) * nnis_pkg::PROD_W'(src_width_ff);
      enq_entry.num_y = nnis_pkg::PROD_W'(pos_y) * nnis_pkg::PROD_W'(src_height_ff);
      enq_entry.den_x = dst_width_ff;
      enq_entry.den_y = dst_height_ff;
   end

endmodule

// ===== rtl/core/nnis_queue.sv =====
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nnis_pkg::nnis_entry_type   push_entry,
   input  logic                       pop,
   output logic                       full,
   output logic                       empty,
   output nnis_pkg::nnis_entry_type   head
);

   nnis_pkg::nnis_entry_type          mem_ff [nnis_pkg::QUEUE_DEPTH];
   logic [nnis_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [nnis_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [nnis_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [nnis_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [nnis_pkg::QCNT_W-1:0]       count_ff;
   logic [nnis_pkg::QCNT_W-1:0]       count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full    = (count_ff == nnis_pkg::QCNT_W'(nnis_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and count updates with wraparound.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == nnis_pkg::QPTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == nnis_pkg::QPTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `NNIS_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= nnis_pkg::QCNT_W'(nnis_pkg::QUEUE_DEPTH))

endmodule

// ===== rtl/core/nnis_div.sv =====
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_div (
   input  logic                       clock,
   input  logic                       reset,
   input  nnis_pkg::nnis_div_req_type div_req,
   output nnis_pkg::nnis_div_rsp_type div_rsp
);

   logic                            busy_ff;
   logic                            busy_in;
   logic                            done_ff;
   logic                            done_in;
   logic [nnis_pkg::STEP_W-1:0]     step_ff;
   logic [nnis_pkg::STEP_W-1:0]     step_in;
   logic [nnis_pkg::DIV_W-1:0]      rem_x_ff;
   logic [nnis_pkg::DIV_W-1:0]      rem_x_in;
   logic [nnis_pkg::DIV_W-1:0]      rem_y_ff;
   logic [nnis_pkg::DIV_W-1:0]      rem_y_in;
   logic [nnis_pkg::DIV_W-1:0]      dsh_x_ff;
   logic [nnis_pkg::DIV_W-1:0]      dsh_x_in;
   logic [nnis_pkg::DIV_W-1:0]      dsh_y_ff;
   logic [nnis_pkg::DIV_W-1:0]      dsh_y_in;
   logic [nnis_pkg::Q_W-1:0]        q_x_ff;
   logic [nnis_pkg::Q_W-1:0]        q_x_in;
   logic [nnis_pkg::Q_W-1:0]        q_y_ff;
   logic [nnis_pkg::Q_W-1:0]        q_y_in;
   logic                            ge_x;
   logic                            ge_y;

   assign ge_x = (rem_x_ff >= dsh_x_ff);
   assign ge_y = (rem_y_ff >= dsh_y_ff);

   // Restoring division, one quotient bit per lane per cycle, both lanes in step.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      dsh_x_in = dsh_x_ff;
      dsh_y_in = dsh_y_ff;
      q_x_in   = q_x_ff;
      q_y_in   = q_y_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = nnis_pkg::STEP_W'(nnis_pkg::Q_W);
         rem_x_in = nnis_pkg::DIV_W'(div_req.num_x);
         rem_y_in = nnis_pkg::DIV_W'(div_req.num_y);
         dsh_x_in = nnis_pkg::DIV_W'(div_req.den_x) << (nnis_pkg::Q_W - 1);
         dsh_y_in = nnis_pkg::DIV_W'(div_req.den_y) << (nnis_pkg::Q_W - 1);
         q_x_in   = '0;
         q_y_in   = '0;
      end else if (busy_ff) begin
         rem_x_in = ge_x ? (rem_x_ff - dsh_x_ff) : rem_x_ff;
         rem_y_in = ge_y ? (rem_y_ff - dsh_y_ff) : rem_y_ff;
         q_x_in   = {q_x_ff[nnis_pkg::Q_W-2:0], ge_x};
         q_y_in   = {q_y_ff[nnis_pkg::Q_W-2:0], ge_y};
         dsh_x_in = dsh_x_ff >> 1;
         dsh_y_in = dsh_y_ff >> 1;
         step_in  = step_ff - 1'b1;
         if (step_ff == nnis_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      dsh_x_ff <= dsh_x_in;
      dsh_y_ff <= dsh_y_in;
      q_x_ff   <= q_x_in;
      q_y_ff   <= q_y_in;
   end

   assign div_rsp.busy   = busy_ff;
   assign div_rsp.done   = done_ff;
   assign div_rsp.quot_x = q_x_ff[nnis_pkg::SX_W-1:0];
   assign div_rsp.quot_y = q_y_ff[nnis_pkg::SY_W-1:0];

   `NNIS_ASSERT_NEXT(a_div_starts, clock, reset, div_req.start, busy_ff && (step_ff == nnis_pkg::STEP_W'(nnis_pkg::Q_W)))

endmodule

// ===== rtl/core/nnis_back.sv =====
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  nnis_pkg::nnis_entry_type       q_head,
   output logic                           q_pop,
   output nnis_pkg::nnis_div_req_type     div_req,
   input  nnis_pkg::nnis_div_rsp_type     div_rsp,
   output logic                           empty,
   input  logic                           pop,
   output logic [nnis_pkg::COLOR_W-1:0]   out_red,
   output logic [nnis_pkg::COLOR_W-1:0]   out_green,
   output logic [nnis_pkg::COLOR_W-1:0]   out_blue,
   output logic                           range_error
);

   nnis_pkg::nnis_state_type          state_ff;
   nnis_pkg::nnis_state_type          state_in;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [nnis_pkg::PIXEL_W-1:0]      out_pixel_ff;
   logic [nnis_pkg::PIXEL_W-1:0]      out_pixel_in;
   logic                              out_err_ff;
   logic                              out_err_in;
   logic [nnis_pkg::ADDR_W-1:0]       addr_ff;
   logic [nnis_pkg::ADDR_W-1:0]       addr_in;
   logic                              err_ff;
   logic                              err_in;
   logic                              deliver;
   logic                              ram_we;
   logic                              ram_re;
   logic [nnis_pkg::PIXEL_W-1:0]      ram_rdata;

   // Source frame store.
   nnis_ram #(
      .WIDTH (nnis_pkg::PIXEL_W),
      .DEPTH (nnis_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_head.addr),
      .wr_data (q_head.pixel),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // Sequencer: take a word; store a load, or divide, read the store and hand over a fetch; hand over a fault.
   always_comb begin
      state_in        = state_ff;
      q_pop           = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      deliver         = 1'b0;
      addr_in         = addr_ff;
      err_in          = err_ff;
      div_req.start   = 1'b0;
      div_req.num_x   = q_head.num_x;
      div_req.num_y   = q_head.num_y;
      div_req.den_x   = q_head.den_x;
      div_req.den_y   = q_head.den_y;
      case (state_ff)
         nnis_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_head.op)
                  nnis_pkg::OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  nnis_pkg::OP_FETCH: begin
                     div_req.start = 1'b1;
                     err_in        = 1'b0;
                     state_in      = nnis_pkg::ST_DIVIDE;
                  end
                  nnis_pkg::OP_FAULT: begin
                     err_in   = 1'b1;
                     state_in = nnis_pkg::ST_DELIVER;
                  end
                  default: begin
                  end
               endcase
            end
         end
         nnis_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               addr_in  = nnis_pkg::ADDR_W'(div_rsp.quot_y) *
                          nnis_pkg::ADDR_W'(nnis_pkg::MAX_SRC_WIDTH) +
                          nnis_pkg::ADDR_W'(div_rsp.quot_x);
               state_in = nnis_pkg::ST_ADDRESS;
            end
         end
         nnis_pkg::ST_ADDRESS: begin
            ram_re   = 1'b1;
            state_in = nnis_pkg::ST_DELIVER;
         end
         nnis_pkg::ST_DELIVER: begin
            if (!out_valid_ff || pop) begin
               deliver  = 1'b1;
               state_in = nnis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nnis_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register in front of the result port.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_err_in   = out_err_ff;
      if (deliver) begin
         out_valid_in = 1'b1;
         out_pixel_in = err_ff ? '0 : ram_rdata;
         out_err_in   = err_ff;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnis_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pixel_ff <= out_pixel_in;
      out_err_ff   <= out_err_in;
      addr_ff      <= addr_in;
      err_ff       <= err_in;
   end

   assign empty       = !out_valid_ff;
   assign out_red     = out_pixel_ff[3*nnis_pkg::COLOR_W-1:2*nnis_pkg::COLOR_W];
   assign out_green   = out_pixel_ff[2*nnis_pkg::COLOR_W-1:nnis_pkg::COLOR_W];
   assign out_blue    = out_pixel_ff[nnis_pkg::COLOR_W-1:0];
   assign range_error = out_err_ff;

   `NNIS_ASSERT_IMPLY(a_div_active, clock, reset, state_ff == nnis_pkg::ST_DIVIDE, div_rsp.busy || div_rsp.done)
   `NNIS_ASSERT_IMPLY(a_result_source, clock, reset, $rose(out_valid_ff), $past(state_ff) == nnis_pkg::ST_DELIVER)

endmodule

// ===== rtl/core/nearest_neighbor_image_scaler_unit.sv =====
// Channel   Handshake           Payload
// request   push / full         req_type, req_pos_x, req_pos_y, req_in_red/green/blue
// response  empty / pop         rsp_out_red, rsp_out_green, rsp_out_blue, rsp_range_error
// config    csr_we              csr_index, csr_wdata
//
// A fetch word passes through the back part in order: it is taken from the queue, the
// divider runs eight restoring steps, the frame store is read and the result is handed over.
// A load word is written to the store as it is taken; an out-of-range fetch goes to hand-over.
// Up to two words wait in the queue; full rises when both slots hold words, and a
// finished result waits in the output register while new words are still taken.
// Reset clears control state only; the frame store has no clearing pass.
module nearest_neighbor_image_scaler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_type,
   input  logic [nnis_pkg::POS_W-1:0]         req_pos_x,
   input  logic [nnis_pkg::POS_W-1:0]         req_pos_y,
   input  logic [nnis_pkg::COLOR_W-1:0]       req_in_red,
   input  logic [nnis_pkg::COLOR_W-1:0]       req_in_green,
   input  logic [nnis_pkg::COLOR_W-1:0]       req_in_blue,
   output logic                               empty,
   input  logic                               pop,
   output logic [nnis_pkg::COLOR_W-1:0]       rsp_out_red,
   output logic [nnis_pkg::COLOR_W-1:0]       rsp_out_green,
   output logic [nnis_pkg::COLOR_W-1:0]       rsp_out_blue,
   output logic                               rsp_range_error,
   input  logic                               csr_we,
   input  logic [nnis_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                          enq_valid;
   nnis_pkg::nnis_entry_type      enq_entry;
   logic                          q_empty;
   logic                          q_pop;
   nnis_pkg::nnis_entry_type      q_head;
   nnis_pkg::nnis_div_req_type    div_req;
   nnis_pkg::nnis_div_rsp_type    div_rsp;

   // Front part: size registers and word classification.
   nnis_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .req_type  (req_type),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .in_red    (req_in_red),
      .in_green  (req_in_green),
      .in_blue   (req_in_blue),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry)
   );

   // Queue between the two parts.
   nnis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (enq_valid),
      .push_entry (enq_entry),
      .pop        (q_pop),
      .full       (full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Coordinate dividers for both axes.
   nnis_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Back part: store access and result delivery.
   nnis_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .empty       (empty),
      .pop         (pop),
      .out_red     (rsp_out_red),
      .out_green   (rsp_out_green),
      .out_blue    (rsp_out_blue),
      .range_error (rsp_range_error)
   );

endmodule
